// File: rtl/pvt_pkg.sv
package pvt_pkg;

  localparam int NUM_COEF = 8;
  localparam int CFG_IDX_W = 8;
  localparam int COEF_SEL_W = $clog2(NUM_COEF);

  localparam logic [63:0] COEF_RESET [NUM_COEF] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // Per-vertex info carried alongside the divider.
  typedef struct packed {
    logic            wzero;  // w was zero, use the undivided path
    logic [2:0]      qneg;   // quotient sign per component
    logic [2:0][31:0] zres;  // undivided, clamped result
    logic [2:0]      zsat;   // undivided result was clamped
  } side_t;

endpackage

// File: rtl/perspective_vertex_transform.sv
// Homogeneous 4x4 vertex transform with perspective divide, Q(32-F).F fixed
// point (F = FRAC_BITS). A vertex (x, y, z) is taken as the row vector
// (x, y, z, 1) times the matrix in the eight coefficient registers (row 3 is
// translation), giving x', y', z', w. With w nonzero each of x', y', z' is
// divided by w (exact, truncated toward zero); with w zero the undivided
// values are returned (floored) and tuser bit 0 is set. Results out of the
// signed 32-bit range clamp and set tuser bit 1. One vertex is accepted every
// cycle while the pipeline advances, passing the multiply, pair-sum, full-sum
// and magnitude registers, the one-bit-per-stage quotient pipeline and the
// sign-and-clamp register. The pipeline advances when the output register is
// empty or being taken, so s_axis_tready follows m_axis_tready. Coefficients
// are read live and must only be written while no vertex is in flight.
module perspective_vertex_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pvt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data,
  // input vertex
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [95:0]                    s_axis_tdata,  // vert_x, vert_y, vert_z
  // projected vertex
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [95:0]                    m_axis_tdata,  // proj_x, proj_y, proj_z
  output logic [1:0]                     m_axis_tuser   // w_was_zero, saturated
);
  import pvt_pkg::*;

  // ---------------- coefficient registers ----------------
  logic [63:0] coef [NUM_COEF];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEF; i++) coef[i] <= COEF_RESET[i];
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_COEF)) begin
      coef[cfg_index[COEF_SEL_W-1:0]] <= cfg_data;
    end
  end

  // Global advance: every stage moves when the output beat can move.
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------- stage 1: products ----------------
  logic                     v1;
  logic signed [63:0]       p1 [3][4];
  logic signed [63:0]       t1 [4];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        for (int i = 0; i < 3; i++) begin
          p1[i][j] <= $signed(s_axis_tdata[32*i +: 32]) *
                      $signed(coef[2*i + j/2][32*(j%2) +: 32]);
        end
        t1[j] <= $signed({{32{coef[6 + j/2][32*(j%2) + 31]}},
                          coef[6 + j/2][32*(j%2) +: 32]}) <<< FRAC_BITS;
      end
    end
  end

  // ---------------- stage 2: pair sums ----------------
  logic                     v2;
  logic signed [64:0]       sa2 [4];
  logic signed [64:0]       sb2 [4];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        sa2[j] <= 65'(p1[0][j]) + 65'(p1[1][j]);
        sb2[j] <= 65'(p1[2][j]) + 65'(t1[j]);
      end
    end
  end

  // ---------------- stage 3: full sums ----------------
  logic                     v3;
  logic signed [65:0]       acc3 [4];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) acc3[j] <= 66'(sa2[j]) + 66'(sb2[j]);
    end
  end

  // ---------------- stage 4: magnitude, zero-w path ----------------
  logic                     v4;
  logic [2:0][63:0]         num4;
  logic [63:0]              den4;
  side_t                    side4;
  side_t                    side_c;
  logic [2:0][63:0]         mag_c;
  logic [63:0]              wmag_c;

  always_comb begin
    logic [65:0] negd;
    logic [65:0] sh;
    logic        fits;
    negd   = -acc3[3];
    wmag_c = acc3[3][65] ? negd[63:0] : acc3[3][63:0];
    side_c.wzero = (acc3[3] == '0);
    for (int j = 0; j < 3; j++) begin
      negd     = -acc3[j];
      mag_c[j] = acc3[j][65] ? negd[63:0] : acc3[j][63:0];
      side_c.qneg[j] = acc3[j][65] ^ acc3[3][65];
      sh   = acc3[j] >>> FRAC_BITS;  // floor
      fits = (sh[65:31] == '0) || (sh[65:31] == '1);
      side_c.zsat[j] = !fits;
      side_c.zres[j] = fits ? sh[31:0] : (sh[65] ? Q_MIN : Q_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num4  <= mag_c;
      den4  <= wmag_c;
      side4 <= side_c;
    end
  end

  // ---------------- divide ----------------
  logic                     vd;
  logic [2:0][31:0]         qd;
  logic [2:0]               ovfd;
  side_t                    sided;

  pvt_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v4),
    .in_num   (num4),
    .in_den   (den4),
    .in_side  (side4),
    .out_valid(vd),
    .out_q    (qd),
    .out_ovf  (ovfd),
    .out_side (sided)
  );

  // ---------------- sign, clamp, output register ----------------
  logic [2:0][31:0] res_c;
  logic             sat_c;

  always_comb begin
    sat_c = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (sided.wzero) begin
        res_c[j] = sided.zres[j];
        sat_c    = sat_c | sided.zsat[j];
      end else if (!sided.qneg[j]) begin
        if (ovfd[j] || qd[j] > Q_MAX) begin
          res_c[j] = Q_MAX;
          sat_c    = 1'b1;
        end else begin
          res_c[j] = qd[j];
        end
      end else begin
        if (ovfd[j] || qd[j] > Q_MIN) begin
          res_c[j] = Q_MIN;
          sat_c    = 1'b1;
        end else begin
          res_c[j] = -qd[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= vd;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {res_c[2], res_c[1], res_c[0]};
      m_axis_tuser <= {sat_c, sided.wzero};
    end
  end

  // ---------------- checks ----------------
  // A clamped beat must carry at least one rail value.
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (m_axis_tdata[31:0]  == Q_MAX || m_axis_tdata[31:0]  == Q_MIN ||
       m_axis_tdata[63:32] == Q_MAX || m_axis_tdata[63:32] == Q_MIN ||
       m_axis_tdata[95:64] == Q_MAX || m_axis_tdata[95:64] == Q_MIN))
    else $error("saturated beat without a clamped component");

  // A stalled pipeline must hold its stage 1 and stage 4 valid flags.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v1) && $stable(v4))
    else $error("pipeline moved during stall");

  // Input ready follows the output side.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready out of step with output");

endmodule

// File: rtl/pvt_div.sv
module pvt_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0][63:0]    in_num,
  input  logic [63:0]         in_den,
  input  pvt_pkg::side_t      in_side,
  output logic                out_valid,
  output logic [2:0][31:0]    out_q,
  output logic [2:0]          out_ovf,
  output pvt_pkg::side_t      out_side
);
  import pvt_pkg::*;

  // 32 restoring steps, one quotient bit per stage, three lanes sharing w.
  localparam int NL    = 32 - FRAC_BITS;
  localparam int STEPS = 32;

  logic [2:0][63:0]   rem   [1:STEPS-1];
  logic [2:0][NL-1:0] num_s [1:STEPS-1];
  logic [63:0]        den_s [1:STEPS-1];
  logic [2:0][31:0]   q_s   [1:STEPS];
  logic [2:0]         ovf_s [1:STEPS];
  logic               vld   [1:STEPS];
  side_t              side_s[1:STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int B = STEPS - 1 - k;

    logic [2:0][63:0]   c_rem;
    logic [2:0][NL-1:0] c_num;
    logic [63:0]        c_den;
    logic [2:0][31:0]   c_q;
    logic [2:0]         c_ovf;
    logic               c_vld;
    side_t              c_side;
    logic [2:0]         nb;
    logic [2:0][63:0]   r_next;
    logic [2:0][31:0]   q_next;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          c_rem[l] = in_num[l] >> NL;
          c_num[l] = in_num[l][NL-1:0];
          c_ovf[l] = (in_num[l] >> NL) >= in_den;
        end
      end
      assign c_den  = in_den;
      assign c_q    = '0;
      assign c_vld  = in_valid;
      assign c_side = in_side;
    end else begin : g_next
      assign c_rem  = rem[k];
      assign c_num  = num_s[k];
      assign c_den  = den_s[k];
      assign c_q    = q_s[k];
      assign c_ovf  = ovf_s[k];
      assign c_vld  = vld[k];
      assign c_side = side_s[k];
    end

    for (genvar l = 0; l < 3; l++) begin : g_bit
      if (B >= FRAC_BITS) begin : g_num
        assign nb[l] = c_num[l][B-FRAC_BITS];
      end else begin : g_zero
        assign nb[l] = 1'b0;
      end
    end

    always_comb begin
      logic [64:0] t;
      logic [64:0] d;
      logic        ge;
      for (int l = 0; l < 3; l++) begin
        t  = {c_rem[l], nb[l]};
        ge = t >= {1'b0, c_den};
        d  = t - {1'b0, c_den};
        r_next[l]    = ge ? d[63:0] : t[63:0];
        q_next[l]    = c_q[l];
        q_next[l][B] = ge;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_s[k+1]    <= q_next;
        ovf_s[k+1]  <= c_ovf;
        side_s[k+1] <= c_side;
      end
    end

    if (k < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1]   <= r_next;
          num_s[k+1] <= c_num;
          den_s[k+1] <= c_den;
        end
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign out_q     = q_s[STEPS];
  assign out_ovf   = ovf_s[STEPS];
  assign out_side  = side_s[STEPS];

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

// Checks the vertex transform against a cycle-free predictor of the matrix
// multiply, the perspective divide, the zero-w path and saturation. Vertices
// stream through with random gaps on both sides. The matrix is rewritten
// only while nothing is in flight.
module testbench;
  import pvt_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 37;

  typedef struct {
    logic [95:0] data;
    logic [1:0]  user;
  } proj_beat_t;

  // Holds its own copy of the coefficient registers and predicts each
  // projected vertex from an accepted input vertex.
  class proj_scoreboard;
    logic [63:0] coef [NUM_COEF];
    proj_beat_t pending [$];
    int errors;

    function new();
      for (int i = 0; i < NUM_COEF; i++) coef[i] = COEF_RESET[i];
      errors = 0;
    endfunction

    function void write_coef(int idx, logic [63:0] val);
      if (idx < NUM_COEF) coef[idx] = val;  // out-of-range index is dropped
    endfunction

    function logic signed [127:0] coef_at(int row, int col);
      logic [63:0] r;
      logic signed [31:0] h;
      r = coef[row * 2 + col / 2];
      h = (col % 2) ? r[63:32] : r[31:0];
      return h;
    endfunction

    // Accepted vertex: compute (x, y, z, 1) * M, then divide or floor.
    function void note_vertex(logic [95:0] vert);
      logic signed [127:0] v [3];
      logic signed [127:0] acc [4];
      logic [127:0] mag_c, mag_w, quo;
      logic signed [127:0] fl;
      logic neg, sat, wzero;
      logic [31:0] res;
      proj_beat_t exp_beat;
      for (int i = 0; i < 3; i++) v[i] = $signed(vert[32*i +: 32]);
      for (int j = 0; j < 4; j++) begin
        acc[j] = coef_at(3, j) <<< FRAC;
        for (int i = 0; i < 3; i++) acc[j] += v[i] * coef_at(i, j);
      end
      wzero = (acc[3] == 0);
      sat = 0;
      for (int j = 0; j < 3; j++) begin
        if (wzero) begin
          // floor toward minus infinity, then clamp
          fl = acc[j] >>> FRAC;
          if (fl > 128'sh7FFF_FFFF) begin
            res = Q_MAX; sat = 1;
          end else if (fl < -128'sh8000_0000) begin
            res = Q_MIN; sat = 1;
          end else begin
            res = fl[31:0];
          end
        end else begin
          // exact quotient of magnitudes, truncated toward zero
          mag_c = (acc[j] < 0) ? -acc[j] : acc[j];
          mag_w = (acc[3] < 0) ? -acc[3] : acc[3];
          quo = (mag_c << FRAC) / mag_w;
          neg = (acc[j] < 0) != (acc[3] < 0);
          if (!neg) begin
            if (quo > 128'h7FFF_FFFF) begin
              res = Q_MAX; sat = 1;
            end else begin
              res = quo[31:0];
            end
          end else begin
            if (quo > 128'h8000_0000) begin
              res = Q_MIN; sat = 1;
            end else begin
              res = -quo[31:0];
            end
          end
        end
        exp_beat.data[32*j +: 32] = res;
      end
      exp_beat.user = {sat, wzero};
      pending.push_back(exp_beat);
    endfunction

    function void check_proj(logic [95:0] data, logic [1:0] user);
      proj_beat_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output beat data=%h user=%b", $time, data, user);
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int j = 0; j < 3; j++)
        if (data[32*j +: 32] !== e.data[32*j +: 32]) begin
          $display("%0t: proj[%0d] expected %h actual %h", $time, j,
                   e.data[32*j +: 32], data[32*j +: 32]);
          errors++;
        end
      if (user[0] !== e.user[0]) begin
        $display("%0t: w_was_zero expected %b actual %b", $time, e.user[0], user[0]);
        errors++;
      end
      if (user[1] !== e.user[1]) begin
        $display("%0t: saturated expected %b actual %b", $time, e.user[1], user[1]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  int send_idle_pct = 0;  // chance in 100 of a gap before each input beat
  int recv_idle_pct = 0;  // chance in 100 of holding tready low

  proj_scoreboard sb = new();

  perspective_vertex_transform #(.FRAC_BITS(FRAC)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),    // vert_x, vert_y, vert_z
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),    // proj_x, proj_y, proj_z
    .m_axis_tuser(m_axis_tuser)     // w_was_zero, saturated
  );

  always #5 clk = ~clk;

  // Receiver backpressure, changed on the falling edge.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Output beats are checked at the rising edge they are taken on.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_proj(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic write_reg(int idx, logic [63:0] val);
    cfg_valid = 1;
    cfg_index = CFG_IDX_W'(idx);
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_coef(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 0;
      @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tdata = {z, y, x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_vertex(s_axis_tdata);
    @(negedge clk);
  endtask

  // Let the pipeline empty before touching the coefficients.
  task automatic drain();
    s_axis_tvalid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return $urandom();
      default: return $urandom_range(32'h1F_FFFF) - 32'h10_0000;  // within +-16.0
    endcase
  endfunction

  function automatic logic [31:0] pick_half();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom();
      default: return $urandom_range(32'h3_FFFF) - 32'h2_0000;  // within +-2.0
    endcase
  endfunction

  task automatic random_matrix();
    logic zero_w;
    zero_w = ($urandom_range(5) == 0);  // w column all zero: undivided path
    for (int i = 0; i < NUM_COEF; i++)
      write_reg(i, {(zero_w && (i % 2)) ? 32'h0 : pick_half(), pick_half()});
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Identity matrix from reset: coordinate extremes pass straight through.
    send_vertex(32'h0, 32'h0, 32'h0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    send_vertex(32'h0000_0001, 32'hFFFF_0000, 32'h1234_5678);
    drain();

    // w column zero: floored undivided results, some clamped.
    write_reg(3, 64'h0);
    write_reg(7, {32'h0, 32'h0001_8000});
    write_reg(2, 64'h0002_0000_0001_0000);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
    send_vertex(32'h0, 32'h0, 32'h0);
    drain();

    // Projection-like matrix: w from z and a zero translation, so z = 0 gives w zero.
    write_reg(5, 64'h0001_0000_0001_0000);
    write_reg(7, 64'h0);
    send_vertex(32'h0003_0000, 32'hFFFE_0000, 32'h0);
    send_vertex(32'h0003_0000, 32'hFFFE_0000, 32'h0002_0000);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_vertex(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
    drain();

    // Coefficient extremes, plus writes to indexes that do not exist.
    for (int i = 0; i < NUM_COEF; i++)
      write_reg(i, (i % 3 == 0) ? 64'hFFFF_FFFF_FFFF_FFFF :
                   (i % 3 == 1) ? 64'h8000_0000_8000_0000 : 64'h7FFF_FFFF_7FFF_FFFF);
    write_reg(NUM_COEF, 64'h0123_4567_89AB_CDEF);
    write_reg((1 << CFG_IDX_W) - 1, 64'hFFFF_FFFF_0000_0000);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
    drain();

    // Random part: three idle profiles, fresh matrix every block.
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 37 : (p == 1) ? 50 : 0;
      recv_idle_pct = (p == 0) ? 50 : (p == 1) ? 37 : 0;
      for (int b = 0; b < 6; b++) begin
        random_matrix();
        for (int k = 0; k < 67; k++) send_vertex(pick_coord(), pick_coord(), pick_coord());
        drain();
      end
    end

    recv_idle_pct = 0;
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
